@@ rtl/core/euler_xyz_point_rotation_defines.svh @@
// assertion macros used by the rotation pipeline
`ifndef EULER_XYZ_POINT_ROTATION_DEFINES_SVH
`define EULER_XYZ_POINT_ROTATION_DEFINES_SVH

// same-cycle implication, disabled in reset
`define EUL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("eul assertion failed");

// next-cycle implication, disabled in reset
`define EUL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("eul assertion failed");

`endif

@@ rtl/core/eul_pkg.sv @@
// types and constants of the euler xyz point rotation pipeline
`default_nettype none
package eul_pkg;

   typedef enum logic [1:0] {
      SEL_X    = 2'd0,
      SEL_Y    = 2'd1,
      SEL_Z    = 2'd2,
      SEL_NONE = 2'd3
   } sel_type;

   localparam logic CSR_OFFSET_X = 1'b0;
   localparam logic CSR_OFFSET_Y = 1'b1;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic [15:0]        angle_a;
      logic [15:0]        angle_b;
      logic [15:0]        angle_c;
      logic [1:0]         req_type;
   } req_type_type;

   typedef struct packed {
      logic signed [31:0] coordinate;
      logic               saturated;
   } rsp_type;

   localparam int CORDIC_STEPS = 31;
   localparam int CORDIC_FRAC  = 30;
   localparam int CORDIC_XW    = 34;
   localparam int CORDIC_ZW    = 34;
   localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
   localparam logic signed [CORDIC_XW-1:0] CORDIC_X0 = 34'sd652032874;

   localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001
   };

endpackage
`default_nettype wire

@@ rtl/core/eul_cordic.sv @@
// pipelined cordic sine and cosine of one binary angle
`default_nettype none
module eul_cordic #(
   parameter int ANGLE_BITS     = 16,
   parameter int TRIG_FRAC_BITS = 15
) (
   input  wire logic                              clock,
   input  wire logic                              en,
   input  wire logic [15:0]                       angle,
   output logic signed [TRIG_FRAC_BITS+1:0]       sin_out,
   output logic signed [TRIG_FRAC_BITS+1:0]       cos_out
);
   import eul_pkg::*;

   localparam int TW = TRIG_FRAC_BITS + 2;
   localparam int RW = 35;
   localparam int SH = CORDIC_FRAC - TRIG_FRAC_BITS;
   localparam logic signed [RW-1:0] ONE = RW'(1) <<< TRIG_FRAC_BITS;

   logic signed [CORDIC_XW-1:0] x_ff [CORDIC_STEPS+1];
   logic signed [CORDIC_XW-1:0] y_ff [CORDIC_STEPS+1];
   logic signed [CORDIC_ZW-1:0] z_ff [CORDIC_STEPS+1];
   logic [1:0]                  q_ff [CORDIC_STEPS+1];

   logic [31:0] ang_ext;
   logic [31:0] a32;
   logic [31:0] qsum;
   logic [1:0]  q_in;
   logic [31:0] res;

   assign ang_ext = 32'(angle);
   assign a32     = {ang_ext[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
   assign qsum    = a32 + 32'h20000000;
   assign q_in    = qsum[31:30];
   assign res     = a32 - {q_in, 30'd0};

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= CORDIC_X0;
         y_ff[0] <= '0;
         z_ff[0] <= CORDIC_ZW'($signed(res));
         q_ff[0] <= q_in;
      end
   end

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
      logic signed [CORDIC_XW-1:0] dx;
      logic signed [CORDIC_XW-1:0] dy;
      logic signed [CORDIC_ZW-1:0] dz;
      assign dx = x_ff[k] >>> k;
      assign dy = y_ff[k] >>> k;
      assign dz = CORDIC_ZW'(ATAN_TURNS[k]);
      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[k+1] <= q_ff[k];
            if (z_ff[k] >= 0) begin
               x_ff[k+1] <= x_ff[k] - dy;
               y_ff[k+1] <= y_ff[k] + dx;
               z_ff[k+1] <= z_ff[k] - dz;
            end else begin
               x_ff[k+1] <= x_ff[k] + dy;
               y_ff[k+1] <= y_ff[k] - dx;
               z_ff[k+1] <= z_ff[k] + dz;
            end
         end
      end
   end

   logic signed [RW-1:0] xr;
   logic signed [RW-1:0] yr;
   logic signed [RW-1:0] xe;
   logic signed [RW-1:0] ye;

   assign xe = RW'(x_ff[CORDIC_STEPS]);
   assign ye = RW'(y_ff[CORDIC_STEPS]);

   if (SH > 0) begin : g_rnd
      localparam logic signed [RW-1:0] HALF = RW'(1) <<< (SH - 1);
      assign xr = (xe + HALF) >>> SH;
      assign yr = (ye + HALF) >>> SH;
   end else begin : g_nornd
      assign xr = xe;
      assign yr = ye;
   end

   logic signed [RW-1:0] s_map;
   logic signed [RW-1:0] c_map;
   logic signed [RW-1:0] s_clp;
   logic signed [RW-1:0] c_clp;
   logic signed [TW-1:0] sin_ff;
   logic signed [TW-1:0] cos_ff;

   always_comb begin
      case (q_ff[CORDIC_STEPS])
         2'd0: begin
            s_map = yr;
            c_map = xr;
         end
         2'd1: begin
            s_map = xr;
            c_map = -yr;
         end
         2'd2: begin
            s_map = -yr;
            c_map = -xr;
         end
         default: begin
            s_map = -xr;
            c_map = yr;
         end
      endcase
      s_clp = (s_map > ONE) ? ONE : ((s_map < -ONE) ? -ONE : s_map);
      c_clp = (c_map > ONE) ? ONE : ((c_map < -ONE) ? -ONE : c_map);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= s_clp[TW-1:0];
         cos_ff <= c_clp[TW-1:0];
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule
`default_nettype wire

@@ rtl/core/euler_xyz_point_rotation.sv @@
// Euler XYZ point rotation: the point plus pivot offset is multiplied by
// Rx(a)*Ry(b)*Rz(c), the offset is removed and the selected coordinate is
// returned, saturated to Q16.16. The pipeline takes one transaction per cycle
// while the output is not stalled and holds 37 register stages: 33 in each of
// the three parallel CORDIC lanes (angle load, one stage per iteration, rounded
// sine and cosine), two matrix-entry stages, one point-product stage and the
// output register. The first stage loads at the accepting edge. A stalled
// output holds the whole pipeline. The user must write offsets only while the
// pipeline is empty; the block itself does not enforce this.
`default_nettype none
`include "euler_xyz_point_rotation_defines.svh"
module euler_xyz_point_rotation #(
   parameter int ANGLE_BITS     = 16,
   parameter int TRIG_FRAC_BITS = 15
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire eul_pkg::req_type_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output eul_pkg::rsp_type           rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic                  csr_index,
   input  wire logic [31:0]           csr_data
);
   import eul_pkg::*;

   localparam int TF = TRIG_FRAC_BITS;
   localparam int TW = TF + 2;
   localparam int MW = TF + 3;
   localparam int PW = 33;
   localparam int QW = 35;
   localparam int SW = 38;
   localparam int CL = CORDIC_LAT;
   localparam logic signed [MW-1:0] ONE = MW'(1) <<< TF;
   localparam logic signed [SW-1:0] SMAX = SW'(64'sh7FFFFFFF);
   localparam logic signed [SW-1:0] SMIN = -SW'(64'sh80000000);

   function automatic logic signed [MW-1:0] tmul(
      input logic signed [MW-1:0] a,
      input logic signed [MW-1:0] b
   );
      logic signed [2*MW-1:0] p;
      logic signed [2*MW-1:0] r;
      p = (2*MW)'(a) * (2*MW)'(b);
      r = (p + ((2*MW)'(1) <<< (TF - 1))) >>> TF;
      return r[MW-1:0];
   endfunction

   function automatic logic signed [MW-1:0] clampu(input logic signed [MW-1:0] v);
      return (v > ONE) ? ONE : ((v < -ONE) ? -ONE : v);
   endfunction

   // configuration
   logic signed [31:0] offset_x_ff;
   logic signed [31:0] offset_y_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff <= '0;
         offset_y_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == CSR_OFFSET_X) begin
            offset_x_ff <= csr_data;
         end else begin
            offset_y_ff <= csr_data;
         end
      end
   end

   // pipeline advance
   logic adv;
   logic rsp_valid_ff;
   rsp_type rsp_data_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // delay line alongside the cordic lanes
   logic                 dl_valid_ff [CL];
   sel_type              dl_row_ff   [CL];
   logic signed [PW-1:0] dl_px_ff    [CL];
   logic signed [PW-1:0] dl_py_ff    [CL];
   logic signed [PW-1:0] dl_pz_ff    [CL];

   always_ff @(posedge clock) begin
      if (reset) begin
         dl_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         dl_valid_ff[0] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dl_row_ff[0] <= sel_type'(req_data.req_type);
         dl_px_ff[0]  <= PW'(req_data.point_x) + PW'(offset_x_ff);
         dl_py_ff[0]  <= PW'(req_data.point_y) + PW'(offset_y_ff);
         dl_pz_ff[0]  <= PW'(req_data.point_z);
      end
   end

   for (genvar k = 1; k < CL; k++) begin : g_dl
      always_ff @(posedge clock) begin
         if (reset) begin
            dl_valid_ff[k] <= 1'b0;
         end else if (adv) begin
            dl_valid_ff[k] <= dl_valid_ff[k-1];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dl_row_ff[k] <= dl_row_ff[k-1];
            dl_px_ff[k]  <= dl_px_ff[k-1];
            dl_py_ff[k]  <= dl_py_ff[k-1];
            dl_pz_ff[k]  <= dl_pz_ff[k-1];
         end
      end
   end

   // sine and cosine lanes
   logic signed [TW-1:0] sa;
   logic signed [TW-1:0] ca;
   logic signed [TW-1:0] sb;
   logic signed [TW-1:0] cb;
   logic signed [TW-1:0] sc;
   logic signed [TW-1:0] cc;

   eul_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cordic_a (
      .clock(clock), .en(adv), .angle(req_data.angle_a), .sin_out(sa), .cos_out(ca)
   );
   eul_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cordic_b (
      .clock(clock), .en(adv), .angle(req_data.angle_b), .sin_out(sb), .cos_out(cb)
   );
   eul_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cordic_c (
      .clock(clock), .en(adv), .angle(req_data.angle_c), .sin_out(sc), .cos_out(cc)
   );

   // first products of the selected row
   logic signed [MW-1:0] esa, eca, esb, ecb, esc, ecc;
   logic signed [MW-1:0] ab_in, k1_in, k2_in, k3_in;
   logic signed [MW-1:0] ab_ff, k1_ff, k2_ff, k3_ff, sc_ff, cc_ff;
   logic                 m1_valid_ff;
   sel_type              m1_row_ff;
   logic signed [PW-1:0] m1_px_ff, m1_py_ff, m1_pz_ff;

   assign esa = MW'(sa);
   assign eca = MW'(ca);
   assign esb = MW'(sb);
   assign ecb = MW'(cb);
   assign esc = MW'(sc);
   assign ecc = MW'(cc);

   always_comb begin
      ab_in = tmul((dl_row_ff[CL-1] == SEL_Y) ? esa : eca, esb);
      case (dl_row_ff[CL-1])
         SEL_X: begin
            k1_in = tmul(ecb, ecc);
            k2_in = tmul(ecb, esc);
            k3_in = esb;
         end
         SEL_Y: begin
            k1_in = tmul(eca, esc);
            k2_in = tmul(eca, ecc);
            k3_in = tmul(esa, ecb);
         end
         default: begin
            k1_in = tmul(esa, esc);
            k2_in = tmul(esa, ecc);
            k3_in = tmul(eca, ecb);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else if (adv) begin
         m1_valid_ff <= dl_valid_ff[CL-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ab_ff     <= ab_in;
         k1_ff     <= k1_in;
         k2_ff     <= k2_in;
         k3_ff     <= k3_in;
         sc_ff     <= esc;
         cc_ff     <= ecc;
         m1_row_ff <= dl_row_ff[CL-1];
         m1_px_ff  <= dl_px_ff[CL-1];
         m1_py_ff  <= dl_py_ff[CL-1];
         m1_pz_ff  <= dl_pz_ff[CL-1];
      end
   end

   // matrix entries of the row
   logic signed [MW-1:0] e1, e2;
   logic signed [MW-1:0] m0_in, m1_in, m2_in;
   logic signed [TW-1:0] m0_ff, m1_ff, m2_ff;
   logic                 m2_valid_ff;
   sel_type              m2_row_ff;
   logic signed [PW-1:0] m2_px_ff, m2_py_ff, m2_pz_ff;

   always_comb begin
      e1 = tmul(ab_ff, cc_ff);
      e2 = tmul(ab_ff, sc_ff);
      case (m1_row_ff)
         SEL_X: begin
            m0_in = k1_ff;
            m1_in = -k2_ff;
            m2_in = k3_ff;
         end
         SEL_Y: begin
            m0_in = e1 + k1_ff;
            m1_in = k2_ff - e2;
            m2_in = -k3_ff;
         end
         default: begin
            m0_in = k1_ff - e1;
            m1_in = e2 + k2_ff;
            m2_in = k3_ff;
         end
      endcase
   end

   logic signed [MW-1:0] m0_c, m1_c, m2_c;
   assign m0_c = clampu(m0_in);
   assign m1_c = clampu(m1_in);
   assign m2_c = clampu(m2_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else if (adv) begin
         m2_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m0_ff     <= m0_c[TW-1:0];
         m1_ff     <= m1_c[TW-1:0];
         m2_ff     <= m2_c[TW-1:0];
         m2_row_ff <= m1_row_ff;
         m2_px_ff  <= m1_px_ff;
         m2_py_ff  <= m1_py_ff;
         m2_pz_ff  <= m1_pz_ff;
      end
   end

   // entry times point, rounded back to q16.16
   localparam int XW = TW + PW;
   logic signed [XW-1:0] pr0, pr1, pr2;
   logic signed [XW-1:0] rr0, rr1, rr2;
   localparam logic signed [XW-1:0] XHALF = XW'(1) <<< (TF - 1);

   assign pr0 = XW'(m0_ff) * XW'(m2_px_ff);
   assign pr1 = XW'(m1_ff) * XW'(m2_py_ff);
   assign pr2 = XW'(m2_ff) * XW'(m2_pz_ff);
   assign rr0 = (pr0 + XHALF) >>> TF;
   assign rr1 = (pr1 + XHALF) >>> TF;
   assign rr2 = (pr2 + XHALF) >>> TF;

   logic signed [QW-1:0] t0_ff, t1_ff, t2_ff;
   logic                 p_valid_ff;
   sel_type              p_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (adv) begin
         p_valid_ff <= m2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t0_ff    <= rr0[QW-1:0];
         t1_ff    <= rr1[QW-1:0];
         t2_ff    <= rr2[QW-1:0];
         p_row_ff <= m2_row_ff;
      end
   end

   // sum, offset removal, saturation
   logic signed [SW-1:0] off;
   logic signed [SW-1:0] acc;
   rsp_type              rsp_in;

   always_comb begin
      case (p_row_ff)
         SEL_X:   off = SW'(offset_x_ff);
         SEL_Y:   off = SW'(offset_y_ff);
         default: off = '0;
      endcase
      acc = SW'(t0_ff) + SW'(t1_ff) + SW'(t2_ff) - off;
      rsp_in.saturated = 1'b0;
      if (p_row_ff == SEL_NONE) begin
         rsp_in.coordinate = '0;
      end else if (acc > SMAX) begin
         rsp_in.coordinate = 32'sh7FFFFFFF;
         rsp_in.saturated  = 1'b1;
      end else if (acc < SMIN) begin
         rsp_in.coordinate = 32'sh80000000;
         rsp_in.saturated  = 1'b1;
      end else begin
         rsp_in.coordinate = acc[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `EUL_ASSERT_NEXT(a_invalid_zero, clock, reset,
      adv && p_valid_ff && (p_row_ff == SEL_NONE),
      rsp_valid && (rsp_data.coordinate == 32'sd0) && !rsp_data.saturated)
   `EUL_ASSERT_IMPLY(a_sat_extreme, clock, reset,
      rsp_valid && rsp_data.saturated,
      (rsp_data.coordinate == 32'sh7FFFFFFF) || (rsp_data.coordinate == 32'sh80000000))
   `EUL_ASSERT_NEXT(a_offset_write, clock, reset,
      csr_valid && csr_ready && (csr_index == CSR_OFFSET_X),
      offset_x_ff == $past(csr_data))
   `EUL_ASSERT_NEXT(a_stall_holds, clock, reset,
      !adv && p_valid_ff,
      p_valid_ff && rsp_valid)

endmodule
`default_nettype wire

@@ verif/euler_xyz_point_rotation_tb.sv @@
// testbench for the euler xyz point rotation pipeline: directed and random transactions
`timescale 1ns / 100ps
`default_nettype none
module euler_xyz_point_rotation_tb;
   import eul_pkg::*;

   localparam int LATENCY = 38;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = CSR_OFFSET_X;
   logic [31:0] csr_data = '0;

   logic signed [31:0] pivot_x = '0;
   logic signed [31:0] pivot_y = '0;
   rsp_type expected_coords[$];
   int failures = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   euler_xyz_point_rotation DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint fshift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint rshift(longint v, int s);
      if (s <= 0) return v;
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint unit_clip(longint v);
      if (v > 32768) return 32768;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return rshift(a * b, 15);
   endfunction

   task automatic trig(input logic [15:0] ang, output longint s_o, output longint c_o);
      logic [31:0] turn;
      logic [1:0] quad;
      logic [31:0] resid;
      longint z, x, y, dx, dy, s, c;
      turn = {ang, 16'h0};
      quad = 2'((turn + 32'h20000000) >> 30);
      resid = turn - (32'(quad) << 30);
      z = longint'(signed'(resid));
      x = 652032874;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = fshift(y, i);
         dy = fshift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
         end else begin
            x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
         end
      end
      c = rshift(x, 15);
      s = rshift(y, 15);
      case (quad)
         2'd0: begin s_o = s; c_o = c; end
         2'd1: begin s_o = c; c_o = -s; end
         2'd2: begin s_o = -s; c_o = -c; end
         default: begin s_o = -c; c_o = s; end
      endcase
      s_o = unit_clip(s_o);
      c_o = unit_clip(c_o);
   endtask

   task automatic rotate_point(input req_type_type t, output rsp_type r);
      longint sa, ca, sb, cb, sc, cc, ab, acc;
      longint m[3];
      longint p[3];
      r = '0;
      if (sel_type'(t.req_type) == SEL_NONE) return;
      trig(t.angle_a, sa, ca);
      trig(t.angle_b, sb, cb);
      trig(t.angle_c, sc, cc);
      case (sel_type'(t.req_type))
         SEL_X: begin
            m[0] = qmul(cb, cc); m[1] = -qmul(cb, sc); m[2] = sb;
         end
         SEL_Y: begin
            ab = qmul(sa, sb);
            m[0] = qmul(ab, cc) + qmul(ca, sc);
            m[1] = qmul(ca, cc) - qmul(ab, sc);
            m[2] = -qmul(sa, cb);
         end
         default: begin
            ab = qmul(ca, sb);
            m[0] = qmul(sa, sc) - qmul(ab, cc);
            m[1] = qmul(ab, sc) + qmul(sa, cc);
            m[2] = qmul(ca, cb);
         end
      endcase
      p[0] = longint'(t.point_x) + longint'(pivot_x);
      p[1] = longint'(t.point_y) + longint'(pivot_y);
      p[2] = longint'(t.point_z);
      acc = 0;
      for (int k = 0; k < 3; k++) acc += rshift(unit_clip(m[k]) * p[k], 15);
      if (sel_type'(t.req_type) == SEL_X) acc -= longint'(pivot_x);
      else if (sel_type'(t.req_type) == SEL_Y) acc -= longint'(pivot_y);
      if (acc > 64'sh7FFFFFFF) begin
         acc = 64'sh7FFFFFFF; r.saturated = 1'b1;
      end else if (acc < -64'sh80000000) begin
         acc = -64'sh80000000; r.saturated = 1'b1;
      end
      r.coordinate = acc[31:0];
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout", $time);
         $display("TEST FAILED");
         $finish;
      end
   end

   // random receiver stall
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // result checker
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_coords.size() == 0) begin
            $display("%0t unexpected transaction %h", $time, rsp_data);
            failures++;
         end else begin
            exp_r = expected_coords.pop_front();
            if (rsp_data.coordinate !== exp_r.coordinate)
               begin
               $display("%0t coordinate expected %h actual %h", $time,
                  exp_r.coordinate, rsp_data.coordinate);
               failures++;
            end
            if (rsp_data.saturated !== exp_r.saturated) begin
               $display("%0t saturated expected %b actual %b", $time,
                  exp_r.saturated, rsp_data.saturated);
               failures++;
            end
         end
      end
   end

   task automatic send_point(input req_type_type t);
      rsp_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      rotate_point(t, r);
      req_valid <= 1'b1;
      req_data <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_coords.push_back(r);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (expected_coords.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_offset(input logic idx, input logic [31:0] val);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_OFFSET_X) pivot_x = val;
      else pivot_y = val;
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return $urandom_range(32'h1FFFF) - 32'h10000;
         3: return $urandom_range(32'h1FFFFFF) - 32'h1000000;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type_type rand_point();
      req_type_type t;
      t.point_x = rand_coord();
      t.point_y = rand_coord();
      t.point_z = rand_coord();
      t.angle_a = $urandom_range(3) == 0 ? 16'($urandom_range(3)) << 14 : 16'($urandom);
      t.angle_b = $urandom_range(3) == 0 ? 16'($urandom_range(3)) << 14 : 16'($urandom);
      t.angle_c = $urandom_range(3) == 0 ? 16'($urandom_range(3)) << 14 : 16'($urandom);
      t.req_type = $urandom_range(7) == 0 ? SEL_NONE : 2'($urandom_range(2));
      return t;
   endfunction

   task automatic test_directed;
      req_type_type t;
      logic [15:0] angs[6] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h2000, 16'hFFFF};
      for (int i = 0; i < 6; i++) begin
         for (int s = 0; s < 4; s++) begin
            t.point_x = (i % 2) ? 32'h7FFFFFFF : 32'h80000000;
            t.point_y = (i % 3 == 0) ? 32'h80000000 : 32'h00010000;
            t.point_z = (i < 3) ? 32'h7FFFFFFF : 32'hFFFFFFFF;
            t.angle_a = angs[i];
            t.angle_b = angs[(i + 1) % 6];
            t.angle_c = angs[(i + 2) % 6];
            t.req_type = 2'(s);
            send_point(t);
         end
      end
   endtask

   task automatic test_offset_extremes;
      write_offset(CSR_OFFSET_X, 32'h7FFFFFFF);
      write_offset(CSR_OFFSET_Y, 32'h80000000);
      for (int i = 0; i < 40; i++) send_point(rand_point());
      write_offset(CSR_OFFSET_X, 32'h80000000);
      write_offset(CSR_OFFSET_Y, 32'h7FFFFFFF);
      for (int i = 0; i < 40; i++) send_point(rand_point());
   endtask

   task automatic test_random_phase(input int idle, input int stall, input int n);
      send_idle_pct = idle;
      stall_pct = stall;
      write_offset(CSR_OFFSET_X, $urandom_range(1) ? rand_coord() : 32'h0);
      write_offset(CSR_OFFSET_Y, $urandom_range(1) ? rand_coord() : 32'h0);
      for (int i = 0; i < n; i++) send_point(rand_point());
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_offset_extremes();
      test_random_phase(0, 0, 180);
      test_random_phase(45, 0, 180);
      test_random_phase(0, 45, 180);
      test_random_phase(29, 29, 180);
      send_idle_pct = 0;
      stall_pct = 0;
      drain();
      if (failures == 0 && expected_coords.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
